[design/hex8j_pkg.sv]
// Shared types, codes and tables for the hexahedron Jacobian block.
`timescale 1ns / 1ps
package hex8j_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int REF_WIDTH_DEF   = 16;
   localparam int NODE_COUNT      = 8;
   localparam int NODE_BITS       = 3;
   localparam int AXES            = 3;
   localparam int LANES           = AXES * AXES;

   typedef enum logic {
      ACTION_LOAD = 1'b0,
      ACTION_EVAL = 1'b1
   } action_type;

   // corner reference signs: bit0 xi, bit1 eta, bit2 zeta, set means plus
   localparam logic [AXES-1:0] CORNER_SIGN [NODE_COUNT] = '{
      3'd0, 3'd1, 3'd3, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6
   };

   // control word that travels alongside each node's row and weights
   typedef struct packed {
      logic            valid;
      logic            first;
      logic            last;
      logic [AXES-1:0] neg;
   } mac_ctrl_type;

endpackage

[design/hex8j_mac_array.sv]
// Nine multiply-accumulate lanes that sum coordinate times weight over the corner nodes.
`timescale 1ns / 1ps
module hex8j_mac_array #(
   parameter int COORD_WIDTH = hex8j_pkg::COORD_WIDTH_DEF,
   parameter int REF_WIDTH   = hex8j_pkg::REF_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  hex8j_pkg::mac_ctrl_type                         ctrl_i,
   input  logic [hex8j_pkg::AXES*COORD_WIDTH-1:0]          coord_i,
   input  logic [hex8j_pkg::AXES*(2*REF_WIDTH-1)-1:0]      weight_i,
   output logic [hex8j_pkg::LANES*(COORD_WIDTH+2*REF_WIDTH+3)-1:0] acc_o,
   output logic                                            done_o
);
   import hex8j_pkg::*;

   localparam int WW = 2 * REF_WIDTH - 1;
   localparam int PW = COORD_WIDTH + 2 * REF_WIDTH;
   localparam int AW = PW + 3;

   logic signed [PW-1:0] prod_ff [LANES];
   logic signed [AW-1:0] acc_ff  [LANES];
   logic [LANES-1:0]     neg_ff;
   mac_ctrl_type         ctrl1_ff;
   logic                 done_ff;

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      localparam int C = k / AXES;
      localparam int D = k % AXES;

      logic signed [AW-1:0] base;
      logic signed [AW-1:0] acc_in;

      always_ff @(posedge clock) begin
         prod_ff[k] <= PW'($signed(coord_i[C*COORD_WIDTH +: COORD_WIDTH]))
                     * PW'($signed({1'b0, weight_i[D*WW +: WW]}));
         neg_ff[k]  <= ctrl_i.neg[D];
      end

      always_comb begin
         base   = ctrl1_ff.first ? '0 : acc_ff[k];
         acc_in = neg_ff[k] ? base - AW'(prod_ff[k]) : base + AW'(prod_ff[k]);
      end

      always_ff @(posedge clock) begin
         if (ctrl1_ff.valid) begin
            acc_ff[k] <= acc_in;
         end
      end

      assign acc_o[k*AW +: AW] = acc_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         ctrl1_ff <= ctrl_i;
         done_ff  <= ctrl1_ff.valid && ctrl1_ff.last;
      end
   end

   assign done_o = done_ff;

endmodule

[design/hex8_trilinear_jacobian.sv]
// Top level: node store, reference factors, sequencer and result rounding.
`timescale 1ns / 1ps
//  channel  dir  tdata (lowest bit up)                              tuser
//  req_     in   node_index, first_value, second_value, third_value  action
//  rsp_     out  j_xi_x j_eta_x j_zeta_x j_xi_y .. j_zeta_z          -
//
// A load writes one row of the node store.
// An evaluate passes eight node reads through the product, accumulate, drain and output register
// stages before raising rsp_tvalid; the next request can be taken in the same cycle rsp_tvalid rises.
// Reset clears control only; the node store holds nothing valid until loaded.
// A result held by rsp_tready low does not block loads, nor the next
// evaluate until its own result is due.
module hex8_trilinear_jacobian #(
   parameter int COORD_WIDTH = hex8j_pkg::COORD_WIDTH_DEF,
   parameter int REF_WIDTH   = hex8j_pkg::REF_WIDTH_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                req_tvalid,
   output logic                                                req_tready,
   // node_index, first_value, second_value, third_value, zero fill
   input  logic [((hex8j_pkg::NODE_BITS+3*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // action
   input  logic                                                req_tuser,
   output logic                                                rsp_tvalid,
   input  logic                                                rsp_tready,
   // j_xi_x, j_eta_x, j_zeta_x, j_xi_y, j_eta_y, j_zeta_y, j_xi_z, j_eta_z, j_zeta_z
   output logic [((hex8j_pkg::LANES*COORD_WIDTH+7)/8)*8-1:0]   rsp_tdata
);
   import hex8j_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int RW    = REF_WIDTH;
   localparam int WW    = 2 * RW - 1;
   localparam int AW    = CW + 2 * RW + 3;
   localparam int OS    = 2 * (RW - 2) + 3;
   localparam int QW    = AW + 1 - OS;
   localparam int CMPW  = ((CW > RW) ? CW : RW) + 1;
   localparam int RSP_W = ((LANES * CW + 7) / 8) * 8;

   localparam logic signed [CMPW-1:0] REF_ONE_C =
      {{(CMPW-RW+1){1'b0}}, 1'b1, {(RW-2){1'b0}}};
   localparam logic signed [RW:0] REF_ONE_F = {2'b00, 1'b1, {(RW-2){1'b0}}};
   localparam logic signed [AW:0] ROUND_C   =
      {{(AW+1-OS){1'b0}}, 1'b1, {(OS-1){1'b0}}};
   localparam logic signed [QW-1:0] Q_MAX = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [QW-1:0] Q_MIN = {{(QW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // input unpacking
   logic [NODE_BITS-1:0]   node_index;
   logic signed [CW-1:0]   val [AXES];
   logic                   req_xfer;
   logic                   load_xfer;
   logic                   eval_xfer;

   assign node_index = req_tdata[NODE_BITS-1:0];
   for (genvar a = 0; a < AXES; a++) begin : g_val
      assign val[a] = req_tdata[NODE_BITS + a*CW +: CW];
   end

   assign req_xfer  = req_tvalid && req_tready;
   assign load_xfer = req_xfer && (req_tuser == ACTION_LOAD);
   assign eval_xfer = req_xfer && (req_tuser == ACTION_EVAL);

   // clamp to +-1 and form the factors 1 - v and 1 + v
   logic signed [CMPW-1:0] ve    [AXES];
   logic signed [CMPW-1:0] vc    [AXES];
   logic signed [RW:0]     fm_w  [AXES];
   logic signed [RW:0]     fp_w  [AXES];
   logic [RW-1:0]          fac_m_ff [AXES];
   logic [RW-1:0]          fac_p_ff [AXES];

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         ve[a] = CMPW'(val[a]);
         if (ve[a] > REF_ONE_C) begin
            vc[a] = REF_ONE_C;
         end else if (ve[a] < -REF_ONE_C) begin
            vc[a] = -REF_ONE_C;
         end else begin
            vc[a] = ve[a];
         end
         fm_w[a] = REF_ONE_F - $signed(vc[a][RW:0]);
         fp_w[a] = REF_ONE_F + $signed(vc[a][RW:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (eval_xfer) begin
         for (int a = 0; a < AXES; a++) begin
            fac_m_ff[a] <= fm_w[a][RW-1:0];
            fac_p_ff[a] <= fp_w[a][RW-1:0];
         end
      end
   end

   // node store: one row of x, y, z per corner
   logic [AXES*CW-1:0] node_mem [NODE_COUNT];
   logic [AXES*CW-1:0] row_ff;
   logic [NODE_BITS-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (load_xfer) begin
         node_mem[node_index] <= {val[2], val[1], val[0]};
      end
      row_ff <= node_mem[cnt_ff];
   end

   // per-node weights, registered beside the row read
   state_type          state_ff;
   logic [AXES-1:0]    sg;
   logic [RW-1:0]      fsel  [AXES];
   logic [2*RW-1:0]    wprod [AXES];
   logic [AXES*WW-1:0] w_in;
   logic [AXES*WW-1:0] w_ff;
   mac_ctrl_type       ctrl_in;
   mac_ctrl_type       ctrl_ff;

   always_comb begin
      sg = CORNER_SIGN[cnt_ff];
      for (int a = 0; a < AXES; a++) begin
         fsel[a] = sg[a] ? fac_p_ff[a] : fac_m_ff[a];
      end
      for (int d = 0; d < AXES; d++) begin
         wprod[d] = {{RW{1'b0}}, fsel[(d+1)%AXES]} * {{RW{1'b0}}, fsel[(d+2)%AXES]};
         w_in[d*WW +: WW] = wprod[d][WW-1:0];
      end
      ctrl_in.valid = (state_ff == ST_RUN);
      ctrl_in.first = (cnt_ff == '0);
      ctrl_in.last  = (cnt_ff == NODE_BITS'(NODE_COUNT-1));
      ctrl_in.neg   = ~sg;
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   logic [LANES*AW-1:0] acc;
   logic                acc_done;

   hex8j_mac_array #(
      .COORD_WIDTH (COORD_WIDTH),
      .REF_WIDTH   (REF_WIDTH)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl_i   (ctrl_ff),
      .coord_i  (row_ff),
      .weight_i (w_ff),
      .acc_o    (acc),
      .done_o   (acc_done)
   );

   // scale by 0.125, round half up, saturate
   logic signed [AW:0]   rt  [LANES];
   logic signed [QW-1:0] q   [LANES];
   logic [LANES*CW-1:0]  res;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         rt[k] = $signed({acc[k*AW + AW-1], acc[k*AW +: AW]}) + ROUND_C;
         q[k]  = $signed(rt[k][AW:OS]);
         if (q[k] > Q_MAX) begin
            res[k*CW +: CW] = Q_MAX[CW-1:0];
         end else if (q[k] < Q_MIN) begin
            res[k*CW +: CW] = Q_MIN[CW-1:0];
         end else begin
            res[k*CW +: CW] = q[k][CW-1:0];
         end
      end
   end

   // sequencer and output register
   logic                rsp_valid_ff;
   logic [LANES*CW-1:0] rsp_data_ff;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_FINISH && slot_free) ||
                         (rsp_valid_ff && !rsp_tready);
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (eval_xfer) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == NODE_BITS'(NODE_COUNT-1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (acc_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (slot_free) begin
                  rsp_data_ff  <= res;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   // checks
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      acc_done |-> (state_ff == ST_DRAIN))
      else $error("accumulation finished outside the drain state");

   a_eval_blocks: assert property (@(posedge clock) disable iff (reset)
      eval_xfer |=> !req_tready)
      else $error("request still taken while an evaluation runs");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && slot_free) |=> (rsp_tvalid && state_ff == ST_IDLE))
      else $error("finished result not presented");

   a_issue_in_run: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.valid |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("node issued outside the run");

endmodule
